/* rtl/bmx_pkg.sv */
// bmx_pkg: shared constants, tables, types and byte-mixing functions for the
// byte permute affine mixer. No dependencies.
package bmx_pkg;

  localparam int unsigned WORK_SIZE = 32;
  localparam int unsigned IDX_W     = $clog2(WORK_SIZE);
  localparam int unsigned SEED_W    = 64;
  localparam int unsigned SEED_BYTES = SEED_W / 8;
  localparam int unsigned BYTE_SEL_W = $clog2(SEED_BYTES);
  localparam logic [7:0]  AFFINE_CONST = 8'h63;

  // Source index for each work byte.
  localparam logic [IDX_W-1:0] IDX_TABLE [WORK_SIZE] = '{
    5'd21, 5'd8,  5'd19, 5'd12, 5'd2,  5'd11, 5'd28, 5'd20,
    5'd7,  5'd5,  5'd9,  5'd1,  5'd22, 5'd27, 5'd16, 5'd31,
    5'd18, 5'd3,  5'd26, 5'd29, 5'd17, 5'd15, 5'd25, 5'd14,
    5'd30, 5'd13, 5'd6,  5'd4,  5'd10, 5'd24, 5'd23, 5'd0
  };

  // Fixed starting bytes of the work array.
  localparam logic [7:0] INIT_BYTES [WORK_SIZE] = '{
    8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };

  // Write request into the work memory.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } wr_req_t;

  function automatic logic [7:0] rotl8(input logic [7:0] v, input logic [2:0] r);
    logic [15:0] t;
    t = {v, v} << r;
    return t[15:8];
  endfunction

  // AES affine map
  function automatic logic [7:0] affine8(input logic [7:0] b);
    return b ^ rotl8(b, 3'd1) ^ rotl8(b, 3'd2) ^ rotl8(b, 3'd3) ^ rotl8(b, 3'd4)
           ^ AFFINE_CONST;
  endfunction

endpackage

/* rtl/byte_permute_affine_mixer.sv */
// byte_permute_affine_mixer: top level, sequencer, seed/digest registers.
// Depends on bmx_pkg, bmx_work_mem, bmx_mix_unit.
//
//   channel | signals                           | direction
//   --------+-----------------------------------+----------
//   in      | in_valid_i, in_stall_o, seed_i    | into block
//   out     | out_valid_o, out_stall_i, digest_o| out of block
//
// From input transfer to the earliest digest transfer a seed goes through these
// steps: load the work memory (one write port), prime the read ports, run
// 1024 byte updates (32 rounds x 32 bytes), one per cycle through the shared
// mix unit, post the digest into the output register, then hold out_valid_o
// high. The next seed can transfer at the same edge as that digest, so a new
// seed is taken only once the last one's digest is in the output register.
// in_stall_o is high while a seed is in work or the finished digest waits
// for the output register. rst_ni is asynchronous, active low, and returns
// the sequencer to idle and drops out_valid_o. The work memory has no reset.
module byte_permute_affine_mixer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] seed_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] digest_o
);
  import bmx_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_PRIME = 3'd2;
  localparam logic [2:0] ST_RUN   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORK_SIZE - 1);

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;     // byte position
  logic [IDX_W-1:0] rnd_q, rnd_d;     // round number
  logic [63:0]      seed_q, seed_d;
  logic [63:0]      digest_q, digest_d;
  logic [63:0]      out_q, out_d;
  logic             out_valid_q, out_valid_d;

  wr_req_t          wr;
  logic [IDX_W-1:0] rd_idx;
  logic [7:0]       src_b, cur_b, new_b;
  logic [7:0]       seed_b;
  logic             in_xfer, out_free;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // Next byte to read: during RUN it is the one after the byte being
  // written; wraps from 31 into byte 0 of the next round.
  assign rd_idx = (state_q == ST_RUN) ? cnt_q + 1'b1 : '0;

  bmx_work_mem u_mem (
    .clk_i      (clk_i),
    .wr_i       (wr),
    .src_addr_i (IDX_TABLE[rd_idx]),
    .cur_addr_i (rd_idx),
    .src_o      (src_b),
    .cur_o      (cur_b)
  );

  bmx_mix_unit u_mix (
    .src_i (src_b),
    .cur_i (cur_b),
    .new_o (new_b)
  );

  // Seed byte added to the first eight work bytes, no carry between bytes.
  assign seed_b = (cnt_q[IDX_W-1:BYTE_SEL_W] == '0)
                  ? seed_q[8*cnt_q[BYTE_SEL_W-1:0] +: 8] : 8'd0;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rnd_d       = rnd_q;
    seed_d      = seed_q;
    digest_d    = digest_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    wr          = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          seed_d   = seed_i;
          digest_d = '0;
          cnt_d    = '0;
          state_d  = ST_LOAD;
        end
      end
      ST_LOAD: begin
        wr.en   = 1'b1;
        wr.addr = cnt_q;
        wr.data = INIT_BYTES[cnt_q] + seed_b;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == LAST_IDX) begin
          state_d = ST_PRIME;
        end
      end
      ST_PRIME: begin
        cnt_d   = '0;
        rnd_d   = '0;
        state_d = ST_RUN;
      end
      ST_RUN: begin
        wr.en   = 1'b1;
        wr.addr = cnt_q;
        wr.data = new_b;
        // byte j is final for round j once written; later bytes of the
        // round never touch it
        if (cnt_q == rnd_q) begin
          digest_d[8*rnd_q[BYTE_SEL_W-1:0] +: 8] =
            digest_q[8*rnd_q[BYTE_SEL_W-1:0] +: 8] ^ new_b;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_IDX) begin
          rnd_d = rnd_q + 1'b1;
          if (rnd_q == LAST_IDX) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_d       = digest_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seed_q   <= seed_d;
    digest_q <= digest_d;
    out_q    <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign digest_o    = out_q;

  // A seed transfer starts the load at byte 0.
  a_xfer_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ST_LOAD) && (cnt_q == '0))
    else $error("seed transfer did not start the load");

  // The last update of the last round ends the run.
  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_RUN) && (cnt_q == LAST_IDX) && (rnd_q == LAST_IDX))
    |=> (state_q == ST_DONE))
    else $error("run did not end after the last round");

  // A result is only posted out of the done state.
  a_post_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_DONE))
    else $error("digest posted outside the done state");

endmodule

/* rtl/bmx_work_mem.sv */
// bmx_work_mem: 32 x 8 work memory, one write port, two registered read
// ports with write-to-read bypass. Depends on bmx_pkg.
module bmx_work_mem (
  input  logic                         clk_i,
  input  bmx_pkg::wr_req_t             wr_i,
  input  logic [bmx_pkg::IDX_W-1:0]    src_addr_i,
  input  logic [bmx_pkg::IDX_W-1:0]    cur_addr_i,
  output logic [7:0]                   src_o,
  output logic [7:0]                   cur_o
);
  import bmx_pkg::*;

  logic [7:0] mem [WORK_SIZE];
  logic [7:0] src_q;
  logic [7:0] cur_q;

  // bypass: a byte written this cycle is seen by a read issued this cycle
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    src_q <= (wr_i.en && (wr_i.addr == src_addr_i)) ? wr_i.data : mem[src_addr_i];
    cur_q <= (wr_i.en && (wr_i.addr == cur_addr_i)) ? wr_i.data : mem[cur_addr_i];
  end

  assign src_o = src_q;
  assign cur_o = cur_q;

endmodule

/* rtl/bmx_mix_unit.sv */
// bmx_mix_unit: shared byte update, cur ^ rotl8(affine(src), cur[2:0]).
// Depends on bmx_pkg.
module bmx_mix_unit (
  input  logic [7:0] src_i,
  input  logic [7:0] cur_i,
  output logic [7:0] new_o
);
  import bmx_pkg::*;

  assign new_o = cur_i ^ rotl8(affine8(src_i), cur_i[2:0]);

endmodule

/* tb/byte_permute_affine_mixer_tb.sv */
// byte_permute_affine_mixer_tb: self-checking testbench for the seed-to-digest mixer.
// Drives seeds through the valid/stall input channel and checks every digest against a
// local model of the mixer. Depends only on the RTL of byte_permute_affine_mixer.
`timescale 1ns / 1ps

module byte_permute_affine_mixer_tb;

  localparam int unsigned RESET_CYCLES   = 10;
  localparam int unsigned DIRECTED_COUNT = 18;
  localparam int unsigned RANDOM_COUNT   = 432;
  // Allow for one seed's time inside the block, plus the longest result stall and the
  // longest sender gap, then take that several times over.
  localparam int unsigned WATCHDOG_LIMIT = 8000;
  // Quiet time after the last digest, so that a late extra digest is still caught.
  localparam int unsigned DRAIN_CYCLES   = 1200;
  // Random items in this range run with both sides at full rate.
  localparam int unsigned FULL_RATE_FIRST = 100;
  localparam int unsigned FULL_RATE_LAST  = 139;
  // Before this random item the sender holds off until every digest is back.
  localparam int unsigned PAUSE_AT_ITEM   = 250;

  // Mixer constants, kept here so that the check does not share the block's tables.
  localparam int unsigned MIX_BYTES  = 32;
  localparam int unsigned MIX_ROUNDS = 32;
  localparam logic [7:0]  AES_AFFINE_XOR = 8'h63;

  localparam logic [4:0] SOURCE_INDEX [MIX_BYTES] = '{
    5'd21, 5'd8,  5'd19, 5'd12, 5'd2,  5'd11, 5'd28, 5'd20,
    5'd7,  5'd5,  5'd9,  5'd1,  5'd22, 5'd27, 5'd16, 5'd31,
    5'd18, 5'd3,  5'd26, 5'd29, 5'd17, 5'd15, 5'd25, 5'd14,
    5'd30, 5'd13, 5'd6,  5'd4,  5'd10, 5'd24, 5'd23, 5'd0
  };

  localparam logic [7:0] START_BYTES [MIX_BYTES] = '{
    8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };

  // Directed seeds. No digest here can be read off without running all 32 rounds,
  // so every row is checked against the local model like the random part.
  localparam logic [63:0] DIRECTED_SEEDS [DIRECTED_COUNT] = '{
    64'h0000_0000_0000_0000,  // plain start bytes
    64'hFFFF_FFFF_FFFF_FFFF,  // every seed byte wraps, no carry between bytes
    64'h0000_0000_0000_0001,  // lowest bit only
    64'h8000_0000_0000_0000,  // highest bit only
    64'h0000_0000_0000_00FF,  // byte 0 wraps to zero
    64'hFF00_0000_0000_0000,  // byte 7 wraps to zero
    64'h0101_0101_0101_0101,  // work bytes 0..7 become 2
    64'hFEFE_FEFE_FEFE_FEFE,  // work bytes 0..7 become 0xFF
    64'hAAAA_AAAA_AAAA_AAAA,
    64'h5555_5555_5555_5555,
    64'h0706_0504_0302_0100,  // every rotate amount in the low bits
    64'h0F0F_0F0F_0F0F_0F0F,
    64'hF0F0_F0F0_F0F0_F0F0,
    64'h7F7F_7F7F_7F7F_7F7F,  // 0x80 after the add
    64'h8080_8080_8080_8080,
    64'h0123_4567_89AB_CDEF,
    64'h0123_4567_89AB_CDEF,  // same seed twice in a row
    64'h0000_0000_0000_0000   // first seed again: nothing carries over between items
  };

  typedef struct packed {
    logic [63:0] seed;
    logic [63:0] digest;
  } digest_expect_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [63:0] seed_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] digest_o;

  digest_expect_t pending_digests [$];
  int unsigned    mismatch_count = 0;
  int unsigned    idle_cycles    = 0;
  bit             full_rate      = 1'b0;

  byte_permute_affine_mixer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .seed_i      (seed_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .digest_o    (digest_o)
  );

  // 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------------
  // Local model of the mixer
  // ---------------------------------------------------------------------------------

  function automatic logic [7:0] byte_rotl(input logic [7:0] v, input logic [2:0] amount);
    if (amount == 3'd0) begin
      return v;
    end
    return (v << amount) | (v >> (4'd8 - amount));
  endfunction

  function automatic logic [7:0] aes_affine(input logic [7:0] b);
    return b ^ byte_rotl(b, 3'd1) ^ byte_rotl(b, 3'd2) ^ byte_rotl(b, 3'd3)
           ^ byte_rotl(b, 3'd4) ^ AES_AFFINE_XOR;
  endfunction

  // Digest of one seed: load, add seed bytes modulo 256, 32 in-place rounds.
  function automatic logic [63:0] mix_digest(input logic [63:0] seed);
    logic [7:0]  work [MIX_BYTES];
    logic [7:0]  src;
    logic [7:0]  cur;
    logic [63:0] acc;
    int unsigned i;
    int unsigned r;
    acc = '0;
    for (i = 0; i < MIX_BYTES; i++) begin
      work[i] = START_BYTES[i];
    end
    for (i = 0; i < 8; i++) begin
      work[i] = work[i] + seed[8*i +: 8];
    end
    for (r = 0; r < MIX_ROUNDS; r++) begin
      // Later bytes of a round see the bytes already updated earlier in it.
      for (i = 0; i < MIX_BYTES; i++) begin
        src     = work[SOURCE_INDEX[i]];
        cur     = work[i];
        work[i] = cur ^ byte_rotl(aes_affine(src), cur[2:0]);
      end
      acc[8*(r % 8) +: 8] = acc[8*(r % 8) +: 8] ^ work[r];
    end
    return acc;
  endfunction

  // ---------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (full_rate) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(1, 3);
    end else if (roll < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Mostly full random seeds; some with a single nonzero byte, some built from the
  // byte values that wrap or nearly wrap the start byte.
  function automatic logic [63:0] random_seed();
    logic [63:0] s;
    int unsigned roll;
    int unsigned k;
    s    = {$urandom(), $urandom()};
    roll = $urandom_range(0, 99);
    if (roll >= 85) begin
      for (k = 0; k < 8; k++) begin
        case ($urandom_range(0, 3))
          0: s[8*k +: 8] = 8'h00;
          1: s[8*k +: 8] = 8'hFF;
          2: s[8*k +: 8] = 8'hFE;
          default: ;
        endcase
      end
    end else if (roll >= 70) begin
      k = $urandom_range(0, 7);
      s = '0;
      s[8*k +: 8] = 8'($urandom_range(0, 255));
    end
    return s;
  endfunction

  // One seed transfer. Called and returns at a falling edge.
  task automatic send_seed(input logic [63:0] s);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    seed_i     = s;
    // Hold the seed steady until the block takes it.
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic report_mismatch(input string detail);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, detail);
  endtask

  // ---------------------------------------------------------------------------------
  // Sender: reset, directed seeds, random seeds, then drain and verdict
  // ---------------------------------------------------------------------------------

  initial begin : seed_sender
    int unsigned n;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    seed_i     = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (n = 0; n < DIRECTED_COUNT; n++) begin
      send_seed(DIRECTED_SEEDS[n]);
    end

    for (n = 0; n < RANDOM_COUNT; n++) begin
      full_rate = (n >= FULL_RATE_FIRST) && (n <= FULL_RATE_LAST);
      if (n == PAUSE_AT_ITEM) begin
        // Let the block run completely dry before the next transfer.
        in_valid_i = 1'b0;
        while (pending_digests.size() != 0) @(negedge clk_i);
      end
      send_seed(random_seed());
    end
    full_rate  = 1'b0;
    in_valid_i = 1'b0;

    while (pending_digests.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatch_count == 0) begin
      $display("byte_permute_affine_mixer_tb: PASS");
    end else begin
      $display("byte_permute_affine_mixer_tb: FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------------
  // Receiver: random stall on the digest channel, changed at the falling edge
  // ---------------------------------------------------------------------------------

  initial begin : digest_stall
    int unsigned hold;
    out_stall_i = 1'b0;
    forever begin
      hold = pick_gap();
      if (hold != 0) begin
        out_stall_i = 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------------
  // Monitor: both channels sampled at the rising edge
  // ---------------------------------------------------------------------------------

  always @(posedge clk_i) begin
    digest_expect_t exp_item;
    digest_expect_t seen;
    bit             moved;
    moved = 1'b0;
    if (rst_ni) begin
      // Input transfer: work out the digest it must produce.
      if (in_valid_i && !in_stall_o) begin
        exp_item.seed   = seed_i;
        exp_item.digest = mix_digest(seed_i);
        pending_digests.push_back(exp_item);
        moved = 1'b1;
      end
      // Output transfer: compare with the oldest expectation.
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (pending_digests.size() == 0) begin
          report_mismatch($sformatf("digest %016h with no seed outstanding", digest_o));
        end else begin
          seen = pending_digests.pop_front();
          if (digest_o !== seen.digest) begin
            report_mismatch($sformatf("seed %016h: digest %016h, expected %016h",
                                      seen.seed, digest_o, seen.digest));
          end
        end
      end
    end

    // Watchdog: too long without any transfer means the block is stuck.
    if (moved) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("[%0t] timeout: no transfer for %0d cycles, %0d digests outstanding",
                 $time, WATCHDOG_LIMIT, pending_digests.size());
        $display("byte_permute_affine_mixer_tb: FAIL");
        $finish;
      end
    end
  end

endmodule
